>>> rtl/paes_pkg.sv
// Package with shared constants and codes of the active/expired priority scheduler.
`timescale 1ns / 1ps

package paes_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int LEVELS_DEF      = 4;
    localparam int ID_BITS_DEF     = 8;

    localparam int FIELD_ID_W  = 8;
    localparam int FIELD_LVL_W = 2;
    localparam int STATUS_W    = 2;

    typedef enum logic {
        OP_ADD      = 1'b0,
        OP_DISPATCH = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED      = 2'd0,
        ST_DROPPED    = 2'd1,
        ST_DISPATCHED = 2'd2,
        ST_NONE_READY = 2'd3
    } status_t;

endpackage

>>> rtl/paes_req_if.sv
// Request channel interface of the scheduler: add and dispatch items.
`timescale 1ns / 1ps

interface paes_req_if
    import paes_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic                   op;
    logic [FIELD_ID_W-1:0]  proc_id;
    logic [FIELD_LVL_W-1:0] prio_level;
    logic                   to_expired;

    modport source (output valid, output op, output proc_id, output prio_level,
                    output to_expired, input ready);
    modport sink (input valid, input op, input proc_id, input prio_level,
                  input to_expired, output ready);
endinterface

>>> rtl/paes_rsp_if.sv
// Response channel interface of the scheduler: one result item per request.
`timescale 1ns / 1ps

interface paes_rsp_if
    import paes_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [FIELD_ID_W-1:0]  out_proc_id;
    logic [FIELD_LVL_W-1:0] out_level;
    logic                   sets_swapped;

    modport source (output valid, output status, output out_proc_id, output out_level,
                    output sets_swapped, input ready);
    modport sink (input valid, input status, input out_proc_id, input out_level,
                  input sets_swapped, output ready);
endinterface

>>> rtl/priority_active_expired_scheduler_top.sv
// Top level of the active/expired multilevel priority ready-queue scheduler.
//
//   Channel  Role    Contents
//   req      sink    op, proc_id, prio_level, to_expired
//   rsp      source  status, out_proc_id, out_level, sets_swapped
//
// After its item is accepted, a result passes the registered read of the queue
// memory and then the output register.
// With rsp.ready held high one item is accepted in every cycle.
// Reset clears all heads, tails, counts and the active set; the queue memory
// itself is not cleared, and no entry is read before it was written.
// A stalled rsp holds the output register, one more item waits in the memory
// read stage, and req.ready stays low until that stage can move on.
`timescale 1ns / 1ps

module priority_active_expired_scheduler_top
    import paes_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int LEVELS      = LEVELS_DEF,
    parameter int ID_BITS     = ID_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    paes_req_if.sink  req,
    paes_rsp_if.source rsp
);

    localparam int MEM_DEPTH = 2 * LEVELS * QUEUE_DEPTH;
    localparam int PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int LVL_W     = $clog2(LEVELS);
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    logic [ID_BITS-1:0] mem [MEM_DEPTH];
    logic [ID_BITS-1:0] rdata_reg;

    logic [PTR_W-1:0] head_reg  [2][LEVELS];
    logic [PTR_W-1:0] head_next [2][LEVELS];
    logic [PTR_W-1:0] tail_reg  [2][LEVELS];
    logic [PTR_W-1:0] tail_next [2][LEVELS];
    logic [CNT_W-1:0] count_reg [2][LEVELS];
    logic [CNT_W-1:0] count_next[2][LEVELS];
    logic             active_reg;
    logic             active_next;

    logic              req_fire;
    logic [LVL_W-1:0]  lvl_sat;
    logic              add_set;
    logic              active_empty;
    logic              disp_set;
    logic              found;
    logic [LVL_W-1:0]  found_lvl;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_addr;
    logic [ID_BITS-1:0] mem_wdata;
    logic [ID_BITS+FIELD_ID_W-1:0] in_id_ext;

    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic             s1_adv;
    status_t          s1_status_reg;
    status_t          s1_status_next;
    logic [LVL_W-1:0] s1_level_reg;
    logic [LVL_W-1:0] s1_level_next;
    logic             s1_swapped_reg;
    logic             s1_swapped_next;

    logic                   out_load;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [STATUS_W-1:0]    out_status_reg;
    logic [FIELD_ID_W-1:0]  out_id_reg;
    logic [FIELD_ID_W-1:0]  out_id_next;
    logic [FIELD_LVL_W-1:0] out_level_reg;
    logic [FIELD_LVL_W-1:0] out_level_next;
    logic                   out_swapped_reg;
    logic [ID_BITS+FIELD_ID_W-1:0]  rd_id_ext;
    logic [LVL_W+FIELD_LVL_W-1:0]   s1_level_ext;

    function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
        if (int'(p) == QUEUE_DEPTH - 1)
        begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    function automatic logic [ADDR_W-1:0] fifo_addr(input logic set, input logic [LVL_W-1:0] lvl,
                                                    input logic [PTR_W-1:0] pos);
        return ADDR_W'((int'(set) * LEVELS + int'(lvl)) * QUEUE_DEPTH + int'(pos));
    endfunction

    assign s1_adv    = !out_valid_reg || rsp.ready;
    assign req.ready = !s1_valid_reg || s1_adv;
    assign req_fire  = req.valid && req.ready;
    assign out_load  = s1_valid_reg && s1_adv;

    assign in_id_ext = {{ID_BITS{1'b0}}, req.proc_id};
    assign mem_wdata = in_id_ext[ID_BITS-1:0];
    assign add_set   = active_reg ^ req.to_expired;

    always_comb
    begin
        if (int'(req.prio_level) > LEVELS - 1)
        begin
            lvl_sat = LVL_W'(LEVELS - 1);
        end
        else
        begin
            lvl_sat = LVL_W'(req.prio_level);
        end
    end

    always_comb
    begin
        active_empty = 1'b1;
        for (int lv = 0; lv < LEVELS; lv++)
        begin
            if (count_reg[active_reg][lv] != '0)
            begin
                active_empty = 1'b0;
            end
        end
        disp_set  = active_reg ^ active_empty;
        found     = 1'b0;
        found_lvl = '0;
        // Scanning upward lets the highest non-empty level win.
        for (int lv = 0; lv < LEVELS; lv++)
        begin
            if (count_reg[disp_set][lv] != '0)
            begin
                found     = 1'b1;
                found_lvl = LVL_W'(lv);
            end
        end
    end

    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        active_next     = active_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_addr        = fifo_addr(add_set, lvl_sat, tail_reg[add_set][lvl_sat]);
        s1_status_next  = ST_ADDED;
        s1_level_next   = '0;
        s1_swapped_next = 1'b0;
        if (req_fire)
        begin
            if (req.op == OP_DISPATCH)
            begin
                active_next     = disp_set;
                s1_swapped_next = active_empty;
                mem_addr        = fifo_addr(disp_set, found_lvl, head_reg[disp_set][found_lvl]);
                if (found)
                begin
                    mem_re                          = 1'b1;
                    head_next[disp_set][found_lvl]  = next_pos(head_reg[disp_set][found_lvl]);
                    count_next[disp_set][found_lvl] = count_reg[disp_set][found_lvl] - CNT_W'(1);
                    s1_status_next                  = ST_DISPATCHED;
                    s1_level_next                   = found_lvl;
                end
                else
                begin
                    s1_status_next = ST_NONE_READY;
                end
            end
            else
            begin
                if (count_reg[add_set][lvl_sat] < CNT_W'(QUEUE_DEPTH))
                begin
                    mem_we                        = 1'b1;
                    tail_next[add_set][lvl_sat]   = next_pos(tail_reg[add_set][lvl_sat]);
                    count_next[add_set][lvl_sat]  = count_reg[add_set][lvl_sat] + CNT_W'(1);
                    s1_status_next                = ST_ADDED;
                end
                else
                begin
                    s1_status_next = ST_DROPPED;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < 2; s++)
            begin
                for (int lv = 0; lv < LEVELS; lv++)
                begin
                    head_reg[s][lv]  <= '0;
                    tail_reg[s][lv]  <= '0;
                    count_reg[s][lv] <= '0;
                end
            end
            active_reg <= 1'b0;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    assign s1_valid_next = req_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    assign out_valid_next = out_load ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);

    assign rd_id_ext    = {{FIELD_ID_W{1'b0}}, rdata_reg};
    assign s1_level_ext = {{FIELD_LVL_W{1'b0}}, s1_level_reg};
    assign out_id_next  = (s1_status_reg == ST_DISPATCHED) ? rd_id_ext[FIELD_ID_W-1:0] : '0;
    assign out_level_next = s1_level_ext[FIELD_LVL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_status_reg  <= s1_status_next;
            s1_level_reg   <= s1_level_next;
            s1_swapped_reg <= s1_swapped_next;
        end
        if (out_load)
        begin
            out_status_reg  <= s1_status_reg;
            out_id_reg      <= out_id_next;
            out_level_reg   <= out_level_next;
            out_swapped_reg <= s1_swapped_reg;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.out_proc_id  = out_id_reg;
    assign rsp.out_level    = out_level_reg;
    assign rsp.sets_swapped = out_swapped_reg;

endmodule

>>> rtl/paes_checker.sv
// Port-level checker of the scheduler and its bind to the top level.
`timescale 1ns / 1ps

module paes_checker
    import paes_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   req_valid,
    input logic                   req_ready,
    input logic                   rsp_valid,
    input logic                   rsp_ready,
    input logic [STATUS_W-1:0]    rsp_status,
    input logic [FIELD_ID_W-1:0]  rsp_out_proc_id,
    input logic [FIELD_LVL_W-1:0] rsp_out_level,
    input logic                   rsp_sets_swapped
);

    logic [1:0] inflight_reg;
    logic [1:0] inflight_next;
    logic       req_fire;
    logic       rsp_fire;

    assign req_fire = req_valid && req_ready;
    assign rsp_fire = rsp_valid && rsp_ready;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (req_fire && !rsp_fire)
        begin
            inflight_next = inflight_reg + 2'd1;
        end
        else if (!req_fire && rsp_fire)
        begin
            inflight_next = inflight_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // The block holds at most two items, and never shows a result it was not given.
    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (inflight_reg != 2'd3) && (!rsp_valid || inflight_reg != 2'd0))
        else $error("scheduler holds an impossible number of items");

    // An add result never carries dispatch fields.
    a_add_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_ADDED || rsp_status == ST_DROPPED)
        |-> (rsp_out_proc_id == '0) && (rsp_out_level == '0) && !rsp_sets_swapped)
        else $error("add result carries dispatch fields");

    // Nothing ready means both sets were empty, so the sets were swapped.
    a_none_ready: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_NONE_READY)
        |-> (rsp_out_proc_id == '0) && (rsp_out_level == '0) && rsp_sets_swapped)
        else $error("empty dispatch result is malformed");

    a_rsp_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result item withdrawn before it was taken");

    a_rsp_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready
        |=> $stable(rsp_status) && $stable(rsp_out_proc_id) && $stable(rsp_out_level)
            && $stable(rsp_sets_swapped))
        else $error("stalled result item changed");

endmodule

bind priority_active_expired_scheduler_top paes_checker u_paes_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_status       (rsp.status),
    .rsp_out_proc_id  (rsp.out_proc_id),
    .rsp_out_level    (rsp.out_level),
    .rsp_sets_swapped (rsp.sets_swapped)
);
